// ===== hdl/bmi_pkg.sv =====
// ----------------------------------------------------------------------------
// bmi_pkg
// shared types and constants of the brake map interpolator
// ----------------------------------------------------------------------------
package bmi_pkg;

  localparam int SPEED_PTS = 16;
  localparam int BRAKE_PTS = 16;
  localparam int SIW = $clog2(SPEED_PTS);
  localparam int BIW = $clog2(BRAKE_PTS);
  localparam int CNTW = $clog2(SPEED_PTS + 1);
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    OP_LD_SPEED = 3'd0,
    OP_LD_BRAKE = 3'd1,
    OP_LD_CELL  = 3'd2,
    OP_FWD      = 3'd3,
    OP_INV      = 3'd4
  } op_t;

  localparam logic [1:0] REG_SPEED_USED = 2'd0;
  localparam logic [1:0] REG_BRAKE_USED = 2'd1;

  typedef struct packed {
    op_t                op;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] lv;
    logic signed [15:0] spd;
    logic signed [15:0] q;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCLAMP,
    ST_SSRCH,
    ST_RDCELL,
    ST_RLERP,
    ST_DIV,
    ST_RSTORE,
    ST_PREP,
    ST_INVCHK,
    ST_BSRCH,
    ST_BLERP,
    ST_BDIV,
    ST_DONE
  } st_t;

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    if (v > 34'sd32767) return 16'sh7fff;
    if (v < -34'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

// ===== hdl/bmi_front.sv =====
// ----------------------------------------------------------------------------
// bmi_front
// accepts items, performs table loads, queues queries for the back end
// ----------------------------------------------------------------------------
module bmi_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bmi_pkg::item_t in_item,
  input  logic          back_busy,
  output logic          q_valid,
  input  logic          q_pop,
  output bmi_pkg::item_t q_item,
  output logic          ld_speed,
  output logic          ld_brake,
  output logic          ld_cell,
  output bmi_pkg::item_t ld_item
);
  import bmi_pkg::*;

  item_t          fifo_r [QDEPTH];
  logic [0:0]     wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           acc, is_q, is_ld;

  // loads wait until every earlier query has finished with the tables
  assign in_stall = (cnt_r == 2'(QDEPTH)) || (is_ld && (cnt_r != 2'd0 || back_busy));
  assign acc      = in_valid && !in_stall;
  assign is_q     = (in_item.op == OP_FWD) || (in_item.op == OP_INV);
  assign is_ld    = (in_item.op == OP_LD_SPEED) || (in_item.op == OP_LD_BRAKE) ||
                    (in_item.op == OP_LD_CELL);
  assign ld_speed = acc && in_item.op == OP_LD_SPEED;
  assign ld_brake = acc && in_item.op == OP_LD_BRAKE;
  assign ld_cell  = acc && in_item.op == OP_LD_CELL;
  assign ld_item  = in_item;
  assign q_valid  = cnt_r != 2'd0;
  assign q_item   = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (acc && is_q) fifo_r[wp_r] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (acc && is_q) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(acc && is_q) - 2'(q_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'(QDEPTH) |-> !(acc && is_q)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QDEPTH)) else $error("queue count out of range");

endmodule

// ===== hdl/bmi_back.sv =====
// ----------------------------------------------------------------------------
// bmi_back
// holds the map and keys, runs row interpolation and the final lookup
// ----------------------------------------------------------------------------
module bmi_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ld_speed,
  input  logic                 ld_brake,
  input  logic                 ld_cell,
  input  bmi_pkg::item_t       ld_item,
  input  logic [4:0]           ns_cfg,
  input  logic [4:0]           nb_cfg,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  bmi_pkg::item_t       q_item,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_result_value,
  output logic                 out_clamped
);
  import bmi_pkg::*;

  logic signed [15:0] skey_r [SPEED_PTS];
  logic signed [15:0] bkey_r [BRAKE_PTS];
  logic signed [15:0] cell_mem [SPEED_PTS*BRAKE_PTS];
  logic signed [15:0] rowv_r [BRAKE_PTS];
  logic signed [15:0] cell_rd_r;

  st_t st_r, st_nxt;
  item_t it_r, it_nxt;
  logic [CNTW-1:0] ns, nb;
  logic [SIW-1:0] si_r, si_nxt;   // speed segment
  logic [BIW-1:0] ri_r, ri_nxt;   // row counter / brake segment
  logic cph_r, cph_nxt;           // cell read phase
  logic signed [15:0] spd_r, spd_nxt, c0_r, c0_nxt, qv_r, qv_nxt;
  logic signed [15:0] res_r, res_nxt;
  logic clamp_r, clamp_nxt, ov_r, ov_nxt;
  logic [SIW+BIW-1:0] rd_addr;

  // divider
  logic [33:0] num_r, num_nxt;    // magnitude
  logic [16:0] den_r, den_nxt;
  logic [33:0] quo_r, quo_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [5:0]  dc_r, dc_nxt;
  logic        neg_r, neg_nxt;
  logic signed [15:0] base_r, base_nxt;
  logic        inv_r, inv_nxt;

  logic signed [16:0] dv, dk;
  logic signed [16:0] dq;
  logic signed [33:0] prod;
  logic [17:0] rsh;
  logic [33:0] rquo;
  logic [BIW-1:0] ia, ib;

  assign ns = (ns_cfg < 5'd2) ? CNTW'(2) : (ns_cfg > 5'(SPEED_PTS)) ? CNTW'(SPEED_PTS)
             : CNTW'(ns_cfg);
  assign nb = (nb_cfg < 5'd2) ? CNTW'(2) : (nb_cfg > 5'(BRAKE_PTS)) ? CNTW'(BRAKE_PTS)
             : CNTW'(nb_cfg);

  assign busy = (st_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (ld_speed) skey_r[ld_item.col[SIW-1:0]] <= ld_item.lv;
    if (ld_brake) bkey_r[ld_item.row[BIW-1:0]] <= ld_item.lv;
    if (st_r == ST_RSTORE) rowv_r[ri_r] <= res_r;
  end

  always_ff @(posedge clk) begin
    if (ld_cell) cell_mem[{ld_item.row[BIW-1:0], ld_item.col[SIW-1:0]}] <= ld_item.lv;
    cell_rd_r <= cell_mem[rd_addr];
  end

  assign rd_addr = {ri_r, cph_r ? si_r + 1'b1 : si_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r <= it_nxt; si_r <= si_nxt; ri_r <= ri_nxt; cph_r <= cph_nxt;
    spd_r <= spd_nxt; c0_r <= c0_nxt; qv_r <= qv_nxt; res_r <= res_nxt;
    clamp_r <= clamp_nxt; num_r <= num_nxt; den_r <= den_nxt; quo_r <= quo_nxt;
    rem_r <= rem_nxt; dc_r <= dc_nxt; neg_r <= neg_nxt; base_r <= base_nxt;
    inv_r <= inv_nxt;
  end

  // inverse keys reversed: segment k uses rows nb-1-k and nb-2-k
  assign ia = BIW'(nb - CNTW'(1) - CNTW'(ri_r));
  assign ib = BIW'(nb - CNTW'(2) - CNTW'(ri_r));

  assign rsh = {rem_r[16:0], num_r[33]};

  always_comb begin
    st_nxt = st_r; it_nxt = it_r; si_nxt = si_r; ri_nxt = ri_r; cph_nxt = cph_r;
    spd_nxt = spd_r; c0_nxt = c0_r; qv_nxt = qv_r; res_nxt = res_r;
    clamp_nxt = clamp_r; num_nxt = num_r; den_nxt = den_r; quo_nxt = quo_r;
    rem_nxt = rem_r; dc_nxt = dc_r; neg_nxt = neg_r; base_nxt = base_r;
    inv_nxt = inv_r; ov_nxt = ov_r;
    q_pop = 1'b0;
    dv = '0; dk = '0; dq = '0; prod = '0; rquo = '0;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          it_nxt = q_item;
          st_nxt = ST_SCLAMP;
        end
      end
      ST_SCLAMP: begin
        spd_nxt = it_r.spd;
        if (it_r.spd > skey_r[SIW'(ns - CNTW'(1))]) spd_nxt = skey_r[SIW'(ns - CNTW'(1))];
        if (spd_nxt < skey_r[0]) spd_nxt = skey_r[0];
        si_nxt = '0;
        st_nxt = ST_SSRCH;
      end
      ST_SSRCH: begin
        if (CNTW'(si_r) < ns - CNTW'(2) && skey_r[si_r + 1'b1] < spd_r) si_nxt = si_r + 1'b1;
        else begin
          ri_nxt = '0;
          cph_nxt = 1'b0;
          st_nxt = ST_RDCELL;
        end
      end
      ST_RDCELL: begin
        // phase 0 issues left read, phase 1 captures it and issues right
        if (!cph_r) cph_nxt = 1'b1;
        else begin
          c0_nxt = cell_rd_r;
          st_nxt = ST_RLERP;
        end
      end
      ST_RLERP: begin
        // cell_rd_r now holds the right cell, c0_r the left one
        dv = 17'(cell_rd_r) - 17'(c0_r);
        dk = 17'(skey_r[si_r + 1'b1]) - 17'(skey_r[si_r]);
        dq = 17'(spd_r) - 17'(skey_r[si_r]);
        prod = 34'(dv) * 34'(dq);
        if (dk < 0) begin dk = -dk; prod = -prod; end
        base_nxt = c0_r;
        inv_nxt = 1'b0;
        if (dk == 0) begin
          res_nxt = c0_r;
          st_nxt = ST_RSTORE;
        end else begin
          neg_nxt = prod < 0;
          num_nxt = prod < 0 ? 34'(-prod) : 34'(prod);
          den_nxt = 17'(dk);
          quo_nxt = '0; rem_nxt = '0; dc_nxt = '0;
          st_nxt = ST_DIV;
        end
      end
      ST_DIV, ST_BDIV: begin
        if (dc_r != 6'd34) begin
          if (rsh >= 18'(den_r)) begin
            rem_nxt = rsh - 18'(den_r);
            quo_nxt = {quo_r[32:0], 1'b1};
          end else begin
            rem_nxt = rsh;
            quo_nxt = {quo_r[32:0], 1'b0};
          end
          num_nxt = {num_r[32:0], 1'b0};
          dc_nxt = dc_r + 6'd1;
        end else begin
          rquo = quo_r + 34'(({rem_r, 1'b0} >= 19'(den_r)) ? 1 : 0);
          res_nxt = sat16(34'(base_r) + (neg_r ? -$signed(rquo) : $signed(rquo)));
          if (st_r == ST_DIV) st_nxt = ST_RSTORE;
          else st_nxt = ST_DONE;
        end
      end
      ST_RSTORE: begin
        if (CNTW'(ri_r) == nb - CNTW'(1)) st_nxt = ST_PREP;
        else begin
          ri_nxt = ri_r + 1'b1;
          cph_nxt = 1'b0;
          st_nxt = ST_RDCELL;
        end
      end
      ST_PREP: begin
        clamp_nxt = 1'b0;
        ri_nxt = '0;
        if (it_r.op == OP_FWD) begin
          qv_nxt = it_r.q;
          if (it_r.q > bkey_r[BIW'(nb - CNTW'(1))]) begin
            qv_nxt = bkey_r[BIW'(nb - CNTW'(1))]; clamp_nxt = 1'b1;
          end
          if (qv_nxt < bkey_r[0]) begin
            qv_nxt = bkey_r[0]; clamp_nxt = 1'b1;
          end
          st_nxt = ST_BSRCH;
        end else begin
          qv_nxt = it_r.q;
          st_nxt = ST_INVCHK;
        end
      end
      ST_INVCHK: begin
        if (qv_r < rowv_r[BIW'(nb - CNTW'(1))]) begin
          res_nxt = bkey_r[BIW'(nb - CNTW'(1))]; clamp_nxt = 1'b1; st_nxt = ST_DONE;
        end else if (rowv_r[0] < qv_r) begin
          res_nxt = bkey_r[0]; clamp_nxt = 1'b1; st_nxt = ST_DONE;
        end else st_nxt = ST_BSRCH;
      end
      ST_BSRCH: begin
        if (it_r.op == OP_FWD) begin
          if (CNTW'(ri_r) < nb - CNTW'(2) && bkey_r[ri_r + 1'b1] < qv_r) ri_nxt = ri_r + 1'b1;
          else st_nxt = ST_BLERP;
        end else begin
          if (CNTW'(ri_r) < nb - CNTW'(2) && rowv_r[ib] < qv_r) ri_nxt = ri_r + 1'b1;
          else st_nxt = ST_BLERP;
        end
      end
      ST_BLERP: begin
        if (it_r.op == OP_FWD) begin
          base_nxt = rowv_r[ri_r];
          dv = 17'(rowv_r[ri_r + 1'b1]) - 17'(rowv_r[ri_r]);
          dk = 17'(bkey_r[ri_r + 1'b1]) - 17'(bkey_r[ri_r]);
          dq = 17'(qv_r) - 17'(bkey_r[ri_r]);
        end else begin
          base_nxt = bkey_r[ia];
          dv = 17'(bkey_r[ib]) - 17'(bkey_r[ia]);
          dk = 17'(rowv_r[ib]) - 17'(rowv_r[ia]);
          dq = 17'(qv_r) - 17'(rowv_r[ia]);
        end
        prod = 34'(dv) * 34'(dq);
        if (dk < 0) begin dk = -dk; prod = -prod; end
        if (dk == 0) begin
          res_nxt = base_nxt;
          st_nxt = ST_DONE;
        end else begin
          neg_nxt = prod < 0;
          num_nxt = prod < 0 ? 34'(-prod) : 34'(prod);
          den_nxt = 17'(dk);
          quo_nxt = '0; rem_nxt = '0; dc_nxt = '0;
          st_nxt = ST_BDIV;
        end
      end
      ST_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (ov_r && !out_stall && !(st_r == ST_DONE)) ov_nxt = 1'b0;
  end

  logic signed [15:0] ores_r;
  logic oclamp_r;
  always_ff @(posedge clk) begin
    if (st_r == ST_DONE && (!ov_r || !out_stall)) begin
      ores_r <= res_r;
      oclamp_r <= clamp_r;
    end
  end

  assign out_valid = ov_r;
  assign out_result_value = ores_r;
  assign out_clamped = oclamp_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == ST_IDLE) else $error("pop outside idle");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV || st_r == ST_BDIV) |-> dc_r <= 6'd34) else $error("divider overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_result_value) && out_valid)
    else $error("result changed under stall");

endmodule

// ===== hdl/brake_map_interpolator.sv =====
// ----------------------------------------------------------------------------
// brake_map_interpolator
// 2-d brake map with forward and inverse interpolation
// ----------------------------------------------------------------------------
// channel  | direction | handshake
// in_      | input     | in_valid / in_stall
// out_     | output    | out_valid / out_stall
// cfg_     | apb write | psel penable pwrite pready
// a load waits for an empty queue and an idle back end, then is written as it is accepted
// a query clamps and searches the speed keys, interpolates each used row with the 34-step
// restoring divider, then clamps the brake query (an out-of-range inverse one ends here),
// searches and interpolates it with the divider; a flat segment skips the divider
// reset clears control only; keys and cells hold nothing until loaded
// out_stall holds the output register; two queries queue while the back end works
module brake_map_interpolator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [3:0]  in_row_index,
  input  logic [3:0]  in_column_index,
  input  logic signed [15:0] in_load_value,
  input  logic signed [15:0] in_speed,
  input  logic signed [15:0] in_query_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] out_result_value,
  output logic        out_clamped,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bmi_pkg::*;

  logic [4:0] ns_r, nb_r;
  item_t in_item, q_item, ld_item;
  logic q_valid, q_pop, ld_speed, ld_brake, ld_cell, back_busy;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_r <= 5'd2;
      nb_r <= 5'd2;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_SPEED_USED[0]: ns_r <= pwdata[4:0];
        default: nb_r <= pwdata[4:0];
      endcase
    end
  end
  assign prdata = paddr[2] ? {27'd0, nb_r} : {27'd0, ns_r};

  assign in_item.op  = op_t'(in_opcode);
  assign in_item.row = in_row_index;
  assign in_item.col = in_column_index;
  assign in_item.lv  = in_load_value;
  assign in_item.spd = in_speed;
  assign in_item.q   = in_query_value;

  bmi_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_item, .back_busy,
    .q_valid, .q_pop, .q_item, .ld_speed, .ld_brake, .ld_cell, .ld_item
  );

  bmi_back u_back (
    .clk, .rst_n, .ld_speed, .ld_brake, .ld_cell, .ld_item,
    .ns_cfg(ns_r), .nb_cfg(nb_r), .q_valid, .q_pop, .q_item, .busy(back_busy),
    .out_valid, .out_stall, .out_result_value, .out_clamped
  );

endmodule

// ===== verif/brake_map_interpolator_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brake_map_interpolator_check
// watches the load, query and result transfers and the register writes of the
// brake map interpolator, keeps its own copy of the map, predicts each query
// result and compares it field by field with what the block delivers
// ----------------------------------------------------------------------------
module brake_map_interpolator_check
  import bmi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic [3:0]         in_row_index,
  input  logic [3:0]         in_column_index,
  input  logic signed [15:0] in_load_value,
  input  logic signed [15:0] in_speed,
  input  logic signed [15:0] in_query_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_result_value,
  input  logic               out_clamped,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending
);

  typedef logic signed [15:0] tbl_t [16];

  typedef struct {
    logic signed [15:0] value;
    logic               clamped;
  } answer_t;

  tbl_t               speed_key;
  tbl_t               brake_key;
  logic signed [15:0] map_cell [256];
  logic [4:0]         speed_reg;
  logic [4:0]         brake_reg;
  answer_t            answers [$];

  assign pending = answers.size();

  function automatic int used_count(logic [4:0] r);
    if (r < 2) return 2;
    if (r > 16) return 16;
    return int'(r);
  endfunction

  function automatic logic signed [15:0] segment_lerp(tbl_t k, tbl_t v, int n,
                                                     logic signed [15:0] q);
    int     i;
    longint num, den, mag, quo, sum;
    i = 0;
    while (i < n - 2 && k[i + 1] < q) i++;
    den = longint'(k[i + 1]) - longint'(k[i]);
    if (den == 0) return v[i];
    num = (longint'(v[i + 1]) - longint'(v[i])) * (longint'(q) - longint'(k[i]));
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    mag = (num < 0) ? -num : num;
    quo = (mag + den / 2) / den;
    if (num < 0) quo = -quo;
    sum = longint'(v[i]) + quo;
    if (sum > 32767) return 16'sh7fff;
    if (sum < -32768) return 16'sh8000;
    return 16'(sum);
  endfunction

  function automatic answer_t map_query(op_t op, logic signed [15:0] spd,
                                        logic signed [15:0] q);
    int                 ns, nb;
    tbl_t               row_accel, vals, rk, rv;
    logic signed [15:0] s, b;
    answer_t            a;
    ns = used_count(speed_reg);
    nb = used_count(brake_reg);
    s = spd;
    if (s > speed_key[ns - 1]) s = speed_key[ns - 1];
    if (s < speed_key[0]) s = speed_key[0];
    row_accel = '{default: '0};
    vals = '{default: '0};
    rk = '{default: '0};
    rv = '{default: '0};
    for (int r = 0; r < nb; r++) begin
      for (int c = 0; c < ns; c++) vals[c] = map_cell[r * 16 + c];
      row_accel[r] = segment_lerp(speed_key, vals, ns, s);
    end
    a.clamped = 1'b0;
    if (op == OP_FWD) begin
      b = q;
      if (b > brake_key[nb - 1]) begin
        b = brake_key[nb - 1];
        a.clamped = 1'b1;
      end
      if (b < brake_key[0]) begin
        b = brake_key[0];
        a.clamped = 1'b1;
      end
      a.value = segment_lerp(brake_key, row_accel, nb, b);
    end else if (q < row_accel[nb - 1]) begin
      a.value = brake_key[nb - 1];
      a.clamped = 1'b1;
    end else if (row_accel[0] < q) begin
      a.value = brake_key[0];
      a.clamped = 1'b1;
    end else begin
      for (int k = 0; k < nb; k++) begin
        rk[k] = row_accel[nb - 1 - k];
        rv[k] = brake_key[nb - 1 - k];
      end
      a.value = segment_lerp(rk, rv, nb, q);
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t a;
    if (!rst_n) begin
      speed_reg <= 5'd2;
      brake_reg <= 5'd2;
      errors <= 0;
      answers.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'(REG_SPEED_USED * 4)) speed_reg <= pwdata[4:0];
        if (paddr == 3'(REG_BRAKE_USED * 4)) brake_reg <= pwdata[4:0];
      end
      if (in_valid && !in_stall) begin
        case (in_opcode)
          OP_LD_SPEED: speed_key[in_column_index] <= in_load_value;
          OP_LD_BRAKE: brake_key[in_row_index] <= in_load_value;
          OP_LD_CELL:  map_cell[{in_row_index, in_column_index}] <= in_load_value;
          OP_FWD, OP_INV:
            answers.insert(answers.size(),
                           map_query(op_t'(in_opcode), in_speed, in_query_value));
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (answers.size() == 0) begin
          $display("%t: unexpected result transfer value %0d clamped %0b", $time,
                   out_result_value, out_clamped);
          errors <= errors + 1;
        end else begin
          a = answers.pop_front();
          if (a.value !== out_result_value || a.clamped !== out_clamped) begin
            $display("%t: expected value %0d clamped %0b, got value %0d clamped %0b",
                     $time, a.value, a.clamped, out_result_value, out_clamped);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== verif/brake_map_interpolator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brake_map_interpolator_test
// loads a full map, runs directed and random loads and queries over several
// register settings with random gaps and stalls, and reports the checker verdict
// ----------------------------------------------------------------------------
module brake_map_interpolator_test;
  import bmi_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_opcode;
  logic [3:0]         in_row_index;
  logic [3:0]         in_column_index;
  logic signed [15:0] in_load_value;
  logic signed [15:0] in_speed;
  logic signed [15:0] in_query_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_result_value;
  logic               out_clamped;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 errors;
  int                 pending;
  logic               quiet;
  logic               hold_req;

  brake_map_interpolator i_dut (.*);

  brake_map_interpolator_check i_check (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int gap_len();
    int p;
    if (quiet) return 0;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // result side stalls, with one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  task automatic send(op_t op, int row, int col, int lv, int spd, int q);
    int n;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_row_index <= 4'(row);
    in_column_index <= 4'(col);
    in_load_value <= 16'(lv);
    in_speed <= 16'(spd);
    in_query_value <= 16'(q);
    do @(posedge clk); while (in_stall);
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic reg_write(logic [1:0] idx, int value);
    in_valid <= 1'b0;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(idx * 4);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  function automatic int speed_key_val(int c);
    return c * 512 - 1024 + $urandom_range(100);
  endfunction

  function automatic int cell_val(int r, int c);
    return 8000 - r * 1000 - c * 50 + $urandom_range(200);
  endfunction

  task automatic load_keys();
    for (int c = 0; c < 16; c++) send(OP_LD_SPEED, $urandom_range(15), c, speed_key_val(c), 0, 0);
    for (int r = 0; r < 16; r++) send(OP_LD_BRAKE, r, $urandom_range(15), r * 400, 0, 0);
  endtask

  task automatic random_item();
    int p, r, c;
    p = $urandom_range(99);
    r = $urandom_range(15);
    c = $urandom_range(15);
    if (p < 25)
      send(OP_FWD, r, c, $urandom, $urandom_range(9000) - 1500, $urandom_range(7000) - 500);
    else if (p < 45)
      send(OP_INV, r, c, $urandom, $urandom_range(9000) - 1500, $urandom_range(18000) - 9000);
    else if (p < 52)
      send(op_t'($urandom_range(OP_INV, OP_FWD)), r, c, $urandom, $urandom, $urandom);
    else if (p < 80)
      send(OP_LD_CELL, r, c, cell_val(r, c), $urandom, $urandom);
    else if (p < 88)
      send(OP_LD_SPEED, r, c, speed_key_val(c), $urandom, $urandom);
    else if (p < 94)
      send(OP_LD_BRAKE, r, c, r * 400 + $urandom_range(50), $urandom, $urandom);
    else if (p < 97)
      send(op_t'($urandom_range(OP_LD_CELL)), r, c, $urandom, $urandom, $urandom);
    else
      send(op_t'($urandom_range(7, 5)), r, c, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int sp [6] = '{2, 16, 5, 0, 31, 9};
    int bp [6] = '{2, 16, 9, 31, 1, 4};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_LD_SPEED;
    in_row_index = '0;
    in_column_index = '0;
    in_load_value = '0;
    in_speed = '0;
    in_query_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet = 1'b1;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_keys();
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++) send(OP_LD_CELL, r, c, cell_val(r, c), 0, 0);
    drain();
    reg_write(REG_SPEED_USED, 4);
    reg_write(REG_BRAKE_USED, 4);

    // directed: clamps on both sides, inverse cases, extremes, ignored codes
    send(OP_FWD, 0, 0, 0, -32768, -32768);
    send(OP_FWD, 15, 15, -1, 32767, 32767);
    send(OP_FWD, 0, 0, 0, 300, 600);
    send(OP_INV, 0, 0, 0, 300, 32767);
    send(OP_INV, 0, 0, 0, 300, -32768);
    send(OP_INV, 0, 0, 0, 300, 5500);
    send(OP_INV, 0, 0, 0, -32768, 0);
    send(op_t'(5), 15, 15, 32767, 32767, 32767);
    send(op_t'(6), 0, 0, -32768, -32768, -32768);
    send(op_t'(7), 5, 10, 1234, 0, 0);
    send(OP_LD_CELL, 0, 0, 32767, 0, 0);
    send(OP_LD_CELL, 0, 1, -32768, 0, 0);
    send(OP_FWD, 0, 0, 0, 0, 0);
    send(OP_LD_SPEED, 0, 1, -924, 0, 0);
    send(OP_LD_BRAKE, 1, 0, 0, 0, 0);
    send(OP_FWD, 0, 0, 0, -600, 0);
    send(OP_INV, 0, 0, 0, -600, 4000);
    send(OP_LD_SPEED, 0, 2, -32768, 0, 0);
    send(OP_LD_BRAKE, 2, 0, 32767, 0, 0);
    send(OP_FWD, 0, 0, 0, 200, 1000);
    send(OP_INV, 0, 0, 0, 200, 2000);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      quiet = (ph == 0);
      load_keys();
      reg_write(REG_SPEED_USED, sp[ph]);
      reg_write(REG_BRAKE_USED, bp[ph]);
      if (ph == 2) begin
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++) send(OP_FWD, 0, 0, 0, $urandom_range(4000), $urandom_range(4000));
      end
      for (int i = 0; i < 90; i++) random_item();
      drain();
    end

    if (errors == 0)
      $display("brake_map_interpolator: match");
    else
      $display("brake_map_interpolator: mismatch");
    $finish;
  end

  initial begin
    #100ms;
    $display("brake_map_interpolator: mismatch");
    $finish;
  end

endmodule
